[rtl/cleb_pkg.sv]
package cleb_pkg;

    localparam int DEPTH_DEF = 32;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_LEFT      = 3'd1,
        OP_RIGHT     = 3'd2,
        OP_BACKSPACE = 3'd3,
        OP_PRINT     = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PREV,
        CELL_NEXT,
        CELL_HEAD
    } t_cell_op;

endpackage

[rtl/cleb_cell.sv]
module cleb_cell
    import cleb_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_op   i_op,
    input  logic [7:0] i_char,
    input  logic [7:0] i_prev,
    input  logic [7:0] i_next,
    input  logic [7:0] i_head,
    output logic [7:0] o_q
);

    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD: r_q <= i_char;
            CELL_PREV: r_q <= i_prev;
            CELL_NEXT: r_q <= i_next;
            CELL_HEAD: r_q <= i_head;
            default:   r_q <= r_q;
        endcase
    end

    assign o_q = r_q;

endmodule

[rtl/cursor_line_edit_buffer.sv]
// Line buffer with an edit cursor, held as a row of character cells in text order.
// Slave stream: one command per transfer. tdata[2:0] opcode (insert, left, right,
// backspace, print), tdata[10:3] char for insert; upper bits ignored.
// Master stream: printed characters, one per transfer, in text order, closed by a
// newline with tlast high. tuser carries the sticky dropped-insert flag.
// Edit commands complete as they are taken; insert and backspace shift the cells
// right of the cursor by one place, cursor moves change only the counters.
// During a print the used cells rotate one place per output transfer, cell 0 feeds
// the output register, so after count rotations the text is back in place. No
// command is taken until the newline is in the output register. An insert into
// a full buffer is dropped and sets the sticky flag.
// Reset empties the text and clears the flag and both handshakes; no clearing pass
// is needed. A receiver stall holds the output register and pauses the rotation.
module cursor_line_edit_buffer
    import cleb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [2:0] opcode, [10:3] char_in, [15:11] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] char_out
    output logic        o_m_tlast,
    output logic        o_m_tuser    // [0] dropped_any
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRINT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rem;
    logic          r_drop;
    logic          r_m_valid;
    logic [7:0]    r_m_data;
    logic          r_m_last;
    logic          r_m_user;

    t_opcode     s_op;
    logic [7:0]  s_char;
    logic        s_acc;
    logic        s_out_free;
    logic        s_do_ins;
    logic        s_do_bs;
    logic        s_rot;
    logic [7:0]  s_q [DEPTH];
    t_cell_op    s_cop [DEPTH];

    assign s_op       = t_opcode'(i_s_tdata[2:0]);
    assign s_char     = i_s_tdata[10:3];
    assign o_s_tready = (r_state == ST_IDLE) && i_rst_n;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign s_out_free = !r_m_valid || i_m_tready;
    assign s_do_ins   = s_acc && (s_op == OP_INSERT) && (r_count != CW'(DEPTH));
    assign s_do_bs    = s_acc && (s_op == OP_BACKSPACE) && (r_left != '0);
    assign s_rot      = (r_state == ST_PRINT) && s_out_free && (r_rem != '0);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_comb begin
            s_cop[g] = CELL_HOLD;
            if (s_do_ins) begin
                if (CW'(g) == r_left) begin
                    s_cop[g] = CELL_LOAD;
                end else if (CW'(g) > r_left) begin
                    s_cop[g] = CELL_PREV;
                end
            end else if (s_do_bs) begin
                if (CW'(g) + CW'(1) >= r_left) begin
                    s_cop[g] = CELL_NEXT;
                end
            end else if (s_rot) begin
                if (CW'(g) + CW'(1) < r_count) begin
                    s_cop[g] = CELL_NEXT;
                end else if (CW'(g) + CW'(1) == r_count) begin
                    s_cop[g] = CELL_HEAD;
                end
            end
        end

        cleb_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (s_cop[g]),
            .i_char (s_char),
            .i_prev ((g == 0) ? 8'h00 : s_q[(g == 0) ? 0 : g - 1]),
            .i_next ((g == DEPTH - 1) ? 8'h00 : s_q[(g == DEPTH - 1) ? g : g + 1]),
            .i_head (s_q[0]),
            .o_q    (s_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_left    <= '0;
            r_count   <= '0;
            r_rem     <= '0;
            r_drop    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if ((r_state != ST_PRINT) && r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (s_op)
                            OP_INSERT: begin
                                if (s_do_ins) begin
                                    r_left  <= r_left + CW'(1);
                                    r_count <= r_count + CW'(1);
                                end else begin
                                    r_drop <= 1'b1;
                                end
                            end
                            OP_LEFT: begin
                                if (r_left != '0) begin
                                    r_left <= r_left - CW'(1);
                                end
                            end
                            OP_RIGHT: begin
                                if (r_left != r_count) begin
                                    r_left <= r_left + CW'(1);
                                end
                            end
                            OP_BACKSPACE: begin
                                if (s_do_bs) begin
                                    r_left  <= r_left - CW'(1);
                                    r_count <= r_count - CW'(1);
                                end
                            end
                            OP_PRINT: begin
                                r_rem   <= r_count;
                                r_state <= ST_PRINT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_PRINT: begin
                    if (s_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= r_drop;
                        if (r_rem != '0) begin
                            r_m_data <= s_q[0];
                            r_m_last <= 1'b0;
                            r_rem    <= r_rem - CW'(1);
                        end else begin
                            r_m_data <= NEWLINE_CHAR;
                            r_m_last <= 1'b1;
                            r_state  <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_user;

`ifndef ASSERT_OFF
    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left <= r_count) && (r_count <= CW'(DEPTH)))
        else $error("cursor beyond text or text beyond depth");

    a_last_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata == NEWLINE_CHAR)
        else $error("closing item is not a newline");

    a_print_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (s_op == OP_PRINT) |=> !o_s_tready)
        else $error("command taken while printing");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PRINT) |-> r_rem <= r_count)
        else $error("print count exceeds text length");
`endif

endmodule

[bench/tb.sv]
module tb;
    import cleb_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int LIMIT_CYCLES = 1_200_000;
    localparam int LONG_HOLD = 300;
    localparam int MAX_GAP = 17;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       dropped;
    } t_print_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [2:0] opcode, [10:3] char_in, [15:11] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] char_out
    logic        m_tlast;
    logic        m_tuser;         // [0] dropped_any

    cursor_line_edit_buffer #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    // gap buffer copy of the line
    logic [7:0]  line_mem [DEPTH];
    int          left_n = 0;
    int          right_n = 0;
    logic        drop_seen = 1'b0;
    t_print_beat print_q [$];

    int errors = 0;
    int cmds_sent = 0;
    int prints_sent = 0;
    int drops_seen = 0;
    int beats_checked = 0;
    int cycles = 0;
    int hold_len = 0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_beat(logic [7:0] ch, logic last);
        t_print_beat beat;
        beat.ch = ch;
        beat.last = last;
        beat.dropped = drop_seen;
        print_q.push_back(beat);
    endfunction

    function automatic void apply_edit(logic [2:0] op, logic [7:0] ch);
        case (op)
            OP_INSERT: begin
                if (left_n + right_n >= DEPTH) begin
                    drop_seen = 1'b1;
                    drops_seen++;
                end else begin
                    line_mem[left_n] = ch;
                    left_n++;
                end
            end
            OP_LEFT: begin
                if (left_n > 0) begin
                    line_mem[DEPTH - right_n - 1] = line_mem[left_n - 1];
                    left_n--;
                    right_n++;
                end
            end
            OP_RIGHT: begin
                if (right_n > 0) begin
                    line_mem[left_n] = line_mem[DEPTH - right_n];
                    left_n++;
                    right_n--;
                end
            end
            OP_BACKSPACE: begin
                if (left_n > 0) left_n--;
            end
            OP_PRINT: begin
                for (int i = 0; i < left_n; i++) push_beat(line_mem[i], 1'b0);
                for (int i = DEPTH - right_n; i < DEPTH; i++) push_beat(line_mem[i], 1'b0);
                push_beat(NEWLINE_CHAR, 1'b1);
                prints_sent++;
            end
            default: ;
        endcase
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, ch, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        apply_edit(op, ch);
        cmds_sent++;
    endtask

    task automatic stop_cmds();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (print_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [2:0] pick_op(bit keep_room);
        int r;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_INSERT;
        else if (r < 50) op = OP_LEFT;
        else if (r < 65) op = OP_RIGHT;
        else if (r < 77) op = OP_BACKSPACE;
        else if (r < 92) op = OP_PRINT;
        else op = 3'(OP_PRINT) + 3'($urandom_range(1, 3));
        if (keep_room && op == OP_INSERT && left_n + right_n >= DEPTH) op = OP_BACKSPACE;
        return op;
    endfunction

    // receiver: random stalls, quiet stretches, one long hold on request
    initial begin : sink
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            stall = quiet_rx ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_print_beat want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (print_q.size() == 0) begin
                $display("%0t: unexpected transfer char=%02h last=%b dropped=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                want = print_q.pop_front();
                beats_checked++;
                if (m_tdata !== want.ch) begin
                    $display("%0t: char_out expected %02h actual %02h", $time, want.ch, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: tlast expected %b actual %b", $time, want.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== want.dropped) begin
                    $display("%0t: dropped_any expected %b actual %b",
                             $time, want.dropped, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results outstanding", $time, print_q.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_empty_line();
        send_cmd(OP_PRINT, 8'h00);
        send_cmd(OP_LEFT, 8'hFF);
        send_cmd(OP_RIGHT, 8'hFF);
        send_cmd(OP_BACKSPACE, 8'hFF);
        for (int k = OP_PRINT + 1; k < 8; k++) send_cmd(3'(k), 8'hFF);
        send_cmd(OP_PRINT, 8'hFF);
        stop_cmds();
    endtask

    task automatic test_edits();
        send_cmd(OP_INSERT, 8'h00);
        send_cmd(OP_INSERT, 8'hFF);
        send_cmd(OP_INSERT, 8'h41);
        send_cmd(OP_INSERT, 8'h55);
        send_cmd(OP_PRINT, 8'h00);
        send_cmd(OP_LEFT, 8'h00);
        send_cmd(OP_LEFT, 8'h00);
        send_cmd(OP_INSERT, 8'hAA);
        send_cmd(OP_PRINT, 8'h00);
        send_cmd(OP_RIGHT, 8'h00);
        send_cmd(OP_RIGHT, 8'h00);
        send_cmd(OP_RIGHT, 8'h00);   // already at end
        send_cmd(OP_BACKSPACE, 8'h00);
        repeat (5) send_cmd(OP_LEFT, 8'h00);
        send_cmd(OP_BACKSPACE, 8'h00);   // at start
        send_cmd(OP_PRINT, 8'h00);
        stop_cmds();
    endtask

    task automatic test_random(input int count, input bit keep_room);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                quiet_tx = ($urandom_range(0, 3) == 0);
                quiet_rx = ($urandom_range(0, 3) == 0);
            end
            send_cmd(pick_op(keep_room), 8'($urandom_range(0, 255)));
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        stop_cmds();
    endtask

    task automatic test_full_buffer();
        repeat (4) send_cmd(OP_LEFT, 8'h00);
        while (left_n + right_n < DEPTH) send_cmd(OP_INSERT, 8'($urandom_range(0, 255)));
        repeat (3) send_cmd(OP_INSERT, 8'($urandom_range(0, 255)));
        send_cmd(OP_PRINT, 8'h00);
        send_cmd(OP_LEFT, 8'h00);
        send_cmd(OP_INSERT, 8'h5A);
        send_cmd(OP_BACKSPACE, 8'h00);
        send_cmd(OP_INSERT, 8'hA5);
        send_cmd(OP_PRINT, 8'h00);
        stop_cmds();
    endtask

    // receiver holds off while commands keep coming behind a print
    task automatic test_output_stall();
        wait_drained();
        hold_len = LONG_HOLD;
        quiet_tx = 1'b1;
        send_cmd(OP_PRINT, 8'h00);
        repeat (6) send_cmd(3'($urandom_range(OP_LEFT, OP_BACKSPACE)), 8'h00);
        send_cmd(OP_PRINT, 8'h00);
        quiet_tx = 1'b0;
        stop_cmds();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_line();
        test_edits();
        test_random(200, 1'b1);
        test_full_buffer();
        test_output_stall();
        test_random(190, 1'b0);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d commands with %0d print runs, %0d characters compared",
                 cmds_sent, prints_sent, beats_checked);
        $display("full line reached, %0d inserts dropped, long output hold applied",
                 drops_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[cursor_line_edit_buffer.f]
rtl/cleb_pkg.sv
rtl/cleb_cell.sv
rtl/cursor_line_edit_buffer.sv
bench/tb.sv
